// ===== sv/tdm_pkg.sv =====
// shared widths and defaults for the top-k dot-product memory
package tdm_pkg;
  localparam int EW              = 16;  // element width, q8.8
  localparam int KW              = 5;   // neighbor count width
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int VECTOR_LEN_DEF  = 16;
endpackage

// ===== sv/tdm_div.sv =====
// iterative signed-by-unsigned divider, one quotient bit per cycle, truncating
module tdm_div #(
  parameter int W = 21
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [W-1:0]       dividend_i,
  input  logic [tdm_pkg::KW-1:0]    divisor_i,
  output logic                      done_o,
  output logic signed [W-1:0]       quotient_o
);
  import tdm_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          neg_q, neg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [KW-1:0] rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [KW-1:0] div_q, div_d;
  logic [KW:0]   shifted;
  logic          take;

  assign shifted = {rem_q, quo_q[W-1]};
  assign take    = shifted >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = dividend_i[W-1];
      quo_d  = dividend_i[W-1] ? W'(-dividend_i) : dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = take ? KW'(shifted - {1'b0, div_q}) : shifted[KW-1:0];
      quo_d = {quo_q[W-2:0], take};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

// ===== sv/topk_dot_product_memory.sv =====
// top level of the top-k dot-product key-value memory
// usage:
//   input channel (in_valid_i/in_ready_o) takes one word per element. mode 0
//   streams a key and value element, mode 1 a query element; last closes the
//   vector. a store commits on its last word, evicting the oldest entry when
//   the fill has reached capacity_in_use (apb register at byte 0).
//   a query's last word starts the search: one shared multiplier scores each
//   stored key, the top neighbors entries are picked by repeated scans of the
//   score memory (ties to the older entry), and each element's sum over the
//   picked entries is divided by neighbors in a bit-serial divider.
// after a store's last word the pending key and value are copied into the
// memory element by element; a query scores each entry, then scans the
// score memory once per picked neighbor, then sums and divides each result
// element, paced by the single memory read port and multiplier and the
// serial divider.
// results come out of the output channel (out_valid_o/out_ready_i) one word
// per element; a stalled receiver simply holds the block in its output state,
// no input is taken until the last result word leaves.
// reset empties the memory (no clearing pass; stores hold garbage until
// written) and sets capacity to 16, or to MAX_ENTRIES when that is smaller.
module topk_dot_product_memory #(
  parameter int MAX_ENTRIES   = tdm_pkg::MAX_ENTRIES_DEF,
  parameter int VECTOR_LENGTH = tdm_pkg::VECTOR_LEN_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     mode_i,
  input  logic signed [tdm_pkg::EW-1:0] key_element_i,
  input  logic signed [tdm_pkg::EW-1:0] value_element_i,
  input  logic signed [tdm_pkg::EW-1:0] query_element_i,
  input  logic [tdm_pkg::KW-1:0]   neighbors_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [tdm_pkg::EW-1:0] result_element_o,
  output logic                     result_last_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import tdm_pkg::*;

  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int SLOT_W  = $clog2(MAX_ENTRIES);
  localparam int POS_W   = $clog2(VECTOR_LENGTH + 1);
  localparam int QA_W    = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
  localparam int DEPTH   = MAX_ENTRIES * VECTOR_LENGTH;
  localparam int KA_W    = $clog2(DEPTH);
  localparam int SCORE_W = 2 * EW + $clog2(VECTOR_LENGTH) + 1;
  localparam int SUM_W   = EW + $clog2(MAX_ENTRIES) + 1;
  localparam int CAP_RST = (16 > MAX_ENTRIES) ? MAX_ENTRIES : 16;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CP_RD   = 4'd1;
  localparam logic [3:0] S_CP_WR   = 4'd2;
  localparam logic [3:0] S_SC_LEN  = 4'd3;
  localparam logic [3:0] S_SC_N    = 4'd4;
  localparam logic [3:0] S_SC_RD   = 4'd5;
  localparam logic [3:0] S_SC_MAC  = 4'd6;
  localparam logic [3:0] S_SC_WR   = 4'd7;
  localparam logic [3:0] S_SEL_RD  = 4'd8;
  localparam logic [3:0] S_SEL_CMP = 4'd9;
  localparam logic [3:0] S_SM_INIT = 4'd10;
  localparam logic [3:0] S_SM_RD   = 4'd11;
  localparam logic [3:0] S_SM_ADD  = 4'd12;
  localparam logic [3:0] S_DIV_ST  = 4'd13;
  localparam logic [3:0] S_DIV_WT  = 4'd14;
  localparam logic [3:0] S_OUT     = 4'd15;

  // ring position of an entry given the oldest slot and its age
  function automatic logic [SLOT_W-1:0] ring(input logic [SLOT_W-1:0] base,
                                             input logic [CNT_W-1:0] off);
    logic [CNT_W:0] t;
    t = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (t >= (CNT_W+1)'(MAX_ENTRIES)) t = t - (CNT_W+1)'(MAX_ENTRIES);
    return t[SLOT_W-1:0];
  endfunction

  // control and bookkeeping
  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SLOT_W-1:0] oldest_q, oldest_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              vec_open_q, vec_open_d;
  logic              vec_mode_q, vec_mode_d;
  logic [CNT_W-1:0]  cap_q, cap_d;
  logic [KW-1:0]     kk_q, kk_d;
  logic [POS_W-1:0]  len_q, len_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  r_q, r_d;
  logic [POS_W-1:0]  j_q, j_d;
  logic [POS_W-1:0]  n_q, n_d;
  logic              found_q, found_d;
  logic [SLOT_W-1:0] best_q, best_d;
  logic [MAX_ENTRIES-1:0] chosen_q, chosen_d;

  // datapath
  logic signed [SCORE_W-1:0] acc_q, acc_d;
  logic signed [SCORE_W-1:0] best_sc_q, best_sc_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic signed [EW-1:0]      res_q, res_d;
  logic                      res_last_q, res_last_d;

  // memories
  logic signed [EW-1:0] key_mem [DEPTH];
  logic signed [EW-1:0] val_mem [DEPTH];
  logic [POS_W-1:0]     len_mem [MAX_ENTRIES];
  logic signed [SCORE_W-1:0] score_mem [MAX_ENTRIES];
  logic signed [EW-1:0] qry_mem [VECTOR_LENGTH];
  logic signed [EW-1:0] pkey_mem [VECTOR_LENGTH];
  logic signed [EW-1:0] pval_mem [VECTOR_LENGTH];

  logic signed [EW-1:0] key_rd, val_rd, qry_rd, pkey_rd, pval_rd;
  logic [POS_W-1:0]     len_rd;
  logic signed [SCORE_W-1:0] score_rd;

  logic                 kv_we, len_we, score_we, qry_we, pend_we;
  logic [KA_W-1:0]      kv_waddr, kv_raddr;
  logic [SLOT_W-1:0]    len_waddr, len_raddr;
  logic [POS_W-1:0]     len_wdata;
  logic [QA_W-1:0]      in_addr;

  logic                 accept;
  logic [POS_W-1:0]     posv, newpos;
  logic [SLOT_W-1:0]    age_slot;
  logic [CNT_W-1:0]     keff;
  logic                 evict;
  logic [SLOT_W-1:0]    old_n;
  logic [CNT_W-1:0]     cnt_n;
  logic signed [2*EW-1:0] prod;

  logic                 div_start, div_done;
  logic signed [SUM_W-1:0] div_quo;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign posv       = (vec_open_q && (vec_mode_q != mode_i)) ? '0 : pos_q;
  assign newpos     = (posv < POS_W'(VECTOR_LENGTH)) ? posv + 1'b1 : posv;
  assign in_addr    = posv[QA_W-1:0];
  assign age_slot   = ring(oldest_q, i_q);
  assign keff       = (CNT_W'(kk_q) < count_q) ? CNT_W'(kk_q) : count_q;
  assign evict      = count_q >= cap_q;
  assign old_n      = !evict ? oldest_q :
                      (oldest_q == SLOT_W'(MAX_ENTRIES - 1)) ? '0 : oldest_q + 1'b1;
  assign cnt_n      = evict ? count_q - 1'b1 : count_q;
  assign prod       = qry_rd * key_rd;

  assign qry_we  = accept && mode_i && (posv < POS_W'(VECTOR_LENGTH));
  assign pend_we = accept && !mode_i && (posv < POS_W'(VECTOR_LENGTH));
  assign len_we  = accept && !mode_i && last_i;
  assign len_waddr = ring(old_n, cnt_n);
  assign len_wdata = newpos;
  assign len_raddr = age_slot;
  assign kv_we     = (state_q == S_CP_WR);
  assign kv_waddr  = KA_W'(int'(slot_q) * VECTOR_LENGTH + int'(j_q));
  assign kv_raddr  = KA_W'(int'(age_slot) * VECTOR_LENGTH + int'(j_q));
  assign score_we  = (state_q == S_SC_WR);

  // memory ports, read data registered
  always_ff @(posedge clk_i) begin
    if (kv_we) begin
      key_mem[kv_waddr] <= pkey_rd;
      val_mem[kv_waddr] <= pval_rd;
    end
    key_rd <= key_mem[kv_raddr];
    val_rd <= val_mem[kv_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (len_we) len_mem[len_waddr] <= len_wdata;
    len_rd <= len_mem[len_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (score_we) score_mem[i_q[SLOT_W-1:0]] <= acc_q;
    score_rd <= score_mem[i_q[SLOT_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (qry_we) qry_mem[in_addr] <= query_element_i;
    qry_rd <= qry_mem[j_q[QA_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pkey_mem[in_addr] <= key_element_i;
      pval_mem[in_addr] <= value_element_i;
    end
    pkey_rd <= pkey_mem[j_q[QA_W-1:0]];
    pval_rd <= pval_mem[j_q[QA_W-1:0]];
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    oldest_d   = oldest_q;
    pos_d      = pos_q;
    vec_open_d = vec_open_q;
    vec_mode_d = vec_mode_q;
    kk_d       = kk_q;
    len_d      = len_q;
    slot_d     = slot_q;
    i_d        = i_q;
    r_d        = r_q;
    j_d        = j_q;
    n_d        = n_q;
    found_d    = found_q;
    best_d     = best_q;
    chosen_d   = chosen_q;
    acc_d      = acc_q;
    best_sc_d  = best_sc_q;
    sum_d      = sum_q;
    res_d      = res_q;
    res_last_d = res_last_q;
    div_start  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!last_i) begin
            pos_d      = newpos;
            vec_open_d = 1'b1;
            vec_mode_d = mode_i;
          end else begin
            pos_d      = '0;
            vec_open_d = 1'b0;
            len_d      = newpos;
            j_d        = '0;
            i_d        = '0;
            if (!mode_i) begin
              oldest_d = old_n;
              count_d  = cnt_n + 1'b1;
              slot_d   = len_waddr;
              state_d  = S_CP_RD;
            end else begin
              kk_d    = neighbors_i;
              state_d = (count_q == '0) ? S_SM_INIT : S_SC_LEN;
            end
          end
        end
      end
      S_CP_RD: state_d = S_CP_WR;
      S_CP_WR: begin
        j_d     = j_q + 1'b1;
        state_d = (j_q + 1'b1 == len_q) ? S_IDLE : S_CP_RD;
      end
      S_SC_LEN: state_d = S_SC_N;
      S_SC_N: begin
        n_d     = (len_rd < len_q) ? len_rd : len_q;
        j_d     = '0;
        acc_d   = '0;
        state_d = (len_rd == '0) ? S_SC_WR : S_SC_RD;
      end
      S_SC_RD: state_d = S_SC_MAC;
      S_SC_MAC: begin
        acc_d   = acc_q + {{(SCORE_W-2*EW){prod[2*EW-1]}}, prod};
        j_d     = j_q + 1'b1;
        state_d = (j_q + 1'b1 == n_q) ? S_SC_WR : S_SC_RD;
      end
      S_SC_WR: begin
        chosen_d[i_q[SLOT_W-1:0]] = 1'b0;
        i_d = i_q + 1'b1;
        if (i_q + 1'b1 == count_q) begin
          i_d     = '0;
          r_d     = '0;
          found_d = 1'b0;
          j_d     = '0;
          state_d = (keff == '0) ? S_SM_INIT : S_SEL_RD;
        end else begin
          state_d = S_SC_LEN;
        end
      end
      S_SEL_RD: state_d = S_SEL_CMP;
      S_SEL_CMP: begin
        // strict compare keeps the older entry on a tie
        if (!chosen_q[i_q[SLOT_W-1:0]] && (!found_q || score_rd > best_sc_q)) begin
          best_d    = i_q[SLOT_W-1:0];
          best_sc_d = score_rd;
          found_d   = 1'b1;
        end
        i_d     = i_q + 1'b1;
        state_d = S_SEL_RD;
        if (i_q + 1'b1 == count_q) begin
          chosen_d[best_d] = 1'b1;
          i_d     = '0;
          found_d = 1'b0;
          r_d     = r_q + 1'b1;
          j_d     = '0;
          if (r_q + 1'b1 == keff) state_d = S_SM_INIT;
        end
      end
      S_SM_INIT: begin
        sum_d      = '0;
        i_d        = '0;
        res_last_d = (j_q + 1'b1 == len_q);
        if (kk_q == '0) begin
          res_d   = '0;
          state_d = S_OUT;
        end else begin
          state_d = S_SM_RD;
        end
      end
      S_SM_RD: state_d = (i_q == count_q) ? S_DIV_ST : S_SM_ADD;
      S_SM_ADD: begin
        if (chosen_q[i_q[SLOT_W-1:0]] && (j_q < len_rd)) begin
          sum_d = sum_q + {{(SUM_W-EW){val_rd[EW-1]}}, val_rd};
        end
        i_d     = i_q + 1'b1;
        state_d = S_SM_RD;
      end
      S_DIV_ST: begin
        div_start = 1'b1;
        state_d   = S_DIV_WT;
      end
      S_DIV_WT: begin
        if (div_done) begin
          res_d   = div_quo[EW-1:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          j_d     = j_q + 1'b1;
          state_d = res_last_q ? S_IDLE : S_SM_INIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // apb register, clamped to 1..MAX_ENTRIES
  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && !paddr[2]) begin
      if (pwdata == 32'd0) cap_d = CNT_W'(1);
      else if (pwdata > 32'(MAX_ENTRIES)) cap_d = CNT_W'(MAX_ENTRIES);
      else cap_d = pwdata[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      oldest_q   <= '0;
      pos_q      <= '0;
      vec_open_q <= 1'b0;
      vec_mode_q <= 1'b0;
      cap_q      <= CNT_W'(CAP_RST);
      chosen_q   <= '0;
      i_q        <= '0;
      r_q        <= '0;
      j_q        <= '0;
      found_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      oldest_q   <= oldest_d;
      pos_q      <= pos_d;
      vec_open_q <= vec_open_d;
      vec_mode_q <= vec_mode_d;
      cap_q      <= cap_d;
      chosen_q   <= chosen_d;
      i_q        <= i_d;
      r_q        <= r_d;
      j_q        <= j_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kk_q       <= kk_d;
    len_q      <= len_d;
    slot_q     <= slot_d;
    n_q        <= n_d;
    best_q     <= best_d;
    acc_q      <= acc_d;
    best_sc_q  <= best_sc_d;
    sum_q      <= sum_d;
    res_q      <= res_d;
    res_last_q <= res_last_d;
  end

  tdm_div #(
    .W(SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (kk_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o      = (state_q == S_OUT);
  assign result_element_o = res_q;
  assign result_last_o    = res_last_q;

  // input and output never open together
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result word is pending");

  // fill never exceeds the ring
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond ring size");

  // the last result word hands the block back to the input side
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && result_last_o |=> in_ready_o)
    else $error("block not idle after last result word");

  // a picked entry count never exceeds the neighbor count
  a_pick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones(chosen_q) <= int'(kk_q)))
    else $error("more entries picked than requested");
endmodule
